// File: rtl/core/dicp_pkg.sv
// ----------------------------------------------------------------------------
// dicp_pkg
// Types and constants shared by the disk image chunk parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dicp_pkg;

  localparam int MAX_TRACKS_DEF = 160;
  localparam int ADDR_BITS_DEF  = 24;

  localparam logic [31:0] ID_INFO   = 32'h4F464E49;
  localparam logic [31:0] ID_TMAP   = 32'h50414D54;
  localparam logic [31:0] ID_TRKS   = 32'h534B5254;
  localparam logic [31:0] MAGIC_V1  = 32'h315A4F57;
  localparam logic [31:0] MAGIC_V2  = 32'h325A4F57;
  localparam logic [31:0] SIGNATURE = 32'h7F0A0DFF;
  localparam logic [12:0] V1_ENTRY    = 13'd6656;
  localparam logic [12:0] V1_BYTES_AT = 13'd6400;
  localparam logic [12:0] V1_BITS_END = 13'd6405;
  localparam int          HDR_BYTES   = 12;

  localparam logic [1:0] KIND_INFO = 2'd0;
  localparam logic [1:0] KIND_MAP  = 2'd1;
  localparam logic [1:0] KIND_TRK  = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_MAGIC = 2'd2;

  localparam int REG_IMAGE_SIZE = 0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  rec_kind;
    logic [7:0]  rec_index;
    logic [7:0]  map_value;
    logic [23:0] trk_start;
    logic [15:0] track_bytes;
    logic [31:0] trk_bit_count;
    logic [7:0]  info_version;
    logic [7:0]  info_disk_type;
    logic [7:0]  info_write_protect;
    logic [7:0]  info_synchronized;
    logic [7:0]  info_cleaned;
    logic [1:0]  status;
  } out_item_t;

  // Work handed from front to back: at most one parse record plus end flag.
  typedef struct packed {
    logic      rec_vld;
    out_item_t rec;
    logic      end_vld;
    logic [7:0] end_version;
    logic [1:0] end_status;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/dicp_front.sv
// ----------------------------------------------------------------------------
// dicp_front
// Byte-level parser: header checks, chunk walk and record formation.
// ----------------------------------------------------------------------------
`default_nettype none

module dicp_front import dicp_pkg::*; #(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [23:0] image_size,
  input  wire logic        take,
  input  wire in_item_t    item,
  output cmd_t             cmd
);

  typedef enum logic [1:0] {PH_FILE, PH_CHDR, PH_PAYLOAD, PH_HALT} phase_t;

  localparam logic [ADDR_BITS-1:0] POS_MAX = '1;

  phase_t                phase;
  logic [ADDR_BITS-1:0]  byte_position;
  logic [31:0]           chunk_kind;
  logic [31:0]           chunk_length;
  logic [31:0]           payload_position;
  logic [47:0]           field_shift;
  logic [7:0]            format_version;
  logic [1:0]            header_error;
  // v1 entry bookkeeping: entry offset and entry number of the payload byte
  logic [12:0]           v1_off;
  logic [31:0]           v1_trk;
  logic [32:0]           v1_end;   // (t+1)*6656
  logic [32:0]           v1_base;  // pos of entry start, t*6656 + payload start

  phase_t                phase_n;
  logic [31:0]           kind_n, len_n, pp_n;
  logic [47:0]           sh_n;
  logic [7:0]            ver_n;
  logic [1:0]            err_n;
  cmd_t                  cmd_n;
  logic [7:0]            b;
  logic [32:0]           pos_w;
  logic [47:0]           sh_tmp;
  logic [32:0]           nbytes;
  logic [33:0]           fend;

  assign b     = item.data_byte;
  assign pos_w = 33'(byte_position);

  always_comb begin
    phase_n = phase;
    kind_n  = chunk_kind;
    len_n   = chunk_length;
    pp_n    = payload_position;
    sh_n    = field_shift;
    ver_n   = format_version;
    err_n   = header_error;
    cmd_n   = '0;
    sh_tmp  = '0;
    nbytes  = '0;
    fend    = '0;
    unique case (phase)
      PH_FILE: begin
        if (image_size < 24'(HDR_BYTES)) begin
          err_n   = ST_SHORT;
          phase_n = PH_HALT;
        end else begin
          if (pos_w < 33'd4) begin
            kind_n = chunk_kind | (32'(b) << {byte_position[1:0], 3'b000});
          end else if (pos_w < 33'd8) begin
            len_n = chunk_length | (32'(b) << {byte_position[1:0], 3'b000});
          end
          if (pos_w == 33'd7) begin
            if ((kind_n == MAGIC_V1 || kind_n == MAGIC_V2) && len_n == SIGNATURE) begin
              ver_n = (kind_n == MAGIC_V2) ? 8'd2 : 8'd1;
            end else begin
              err_n   = ST_MAGIC;
              phase_n = PH_HALT;
            end
          end
          if (pos_w >= 33'd11 && phase_n == PH_FILE) begin
            phase_n = PH_CHDR;
            pp_n    = '0;
          end
        end
      end
      PH_CHDR: begin
        if (payload_position == '0 && pos_w + 33'd8 > 33'(image_size)) begin
          phase_n = PH_HALT;
        end else begin
          if (payload_position == '0) begin
            kind_n = '0;
            len_n  = '0;
          end
          if (payload_position < 32'd4) begin
            kind_n = kind_n | (32'(b) << {payload_position[1:0], 3'b000});
          end else begin
            len_n = len_n | (32'(b) << {payload_position[1:0], 3'b000});
          end
          pp_n = payload_position + 32'd1;
          if (pp_n >= 32'd8) begin
            pp_n = '0;
            sh_n = '0;
            if (pos_w + 33'd1 + 33'(len_n) > 33'(image_size)) begin
              phase_n = PH_HALT;
            end else if (len_n != '0) begin
              phase_n = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if (chunk_kind == ID_INFO) begin
          if (payload_position < 32'd5) begin
            sh_n = field_shift | (48'(b) << (6'(payload_position[2:0]) * 6'd8));
          end
          if (payload_position == 32'd4) begin
            ver_n = sh_n[7:0];
            cmd_n.rec_vld                = 1'b1;
            cmd_n.rec.rec_kind           = KIND_INFO;
            cmd_n.rec.info_version       = sh_n[7:0];
            cmd_n.rec.info_disk_type     = sh_n[15:8];
            cmd_n.rec.info_write_protect = sh_n[23:16];
            cmd_n.rec.info_synchronized  = sh_n[31:24];
            cmd_n.rec.info_cleaned       = sh_n[39:32];
          end
        end else if (chunk_kind == ID_TMAP) begin
          if (payload_position < 32'(MAX_TRACKS)) begin
            cmd_n.rec_vld       = 1'b1;
            cmd_n.rec.rec_kind  = KIND_MAP;
            cmd_n.rec.rec_index = payload_position[7:0];
            cmd_n.rec.map_value = b;
          end
        end else if (chunk_kind == ID_TRKS) begin
          if (format_version == 8'd1) begin
            if (v1_off >= V1_BYTES_AT && v1_off <= V1_BITS_END) begin
              sh_n = {b, field_shift[47:8]};
            end
            if (v1_off == V1_BITS_END && v1_trk < 32'(MAX_TRACKS) &&
                v1_end <= 33'(chunk_length)) begin
              cmd_n.rec_vld           = 1'b1;
              cmd_n.rec.rec_kind      = KIND_TRK;
              cmd_n.rec.rec_index     = v1_trk[7:0];
              cmd_n.rec.trk_start     = v1_base[23:0];
              cmd_n.rec.track_bytes   = sh_n[15:0];
              cmd_n.rec.trk_bit_count = sh_n[47:16];
            end
          end else begin
            if (payload_position[2:0] != 3'd2 && payload_position[2:0] != 3'd3) begin
              sh_n = {b, field_shift[47:8]};
            end
            sh_tmp = sh_n;
            if (payload_position[2:0] == 3'd7 &&
                32'(payload_position[31:3]) < 32'(MAX_TRACKS) &&
                {1'b0, payload_position[31:3], 3'b000} + 33'd8 <= 33'(chunk_length) &&
                sh_tmp[15:0] != '0 && sh_tmp[47:16] != '0) begin
              nbytes = (33'(sh_tmp[47:16]) + 33'd7) >> 3;
              fend   = {9'd0, sh_tmp[15:0], 9'd0} + 34'(nbytes);
              if (fend <= 34'(image_size)) begin
                cmd_n.rec_vld           = 1'b1;
                cmd_n.rec.rec_kind      = KIND_TRK;
                cmd_n.rec.rec_index     = payload_position[10:3];
                cmd_n.rec.trk_start     = {sh_tmp[14:0], 9'd0};
                cmd_n.rec.track_bytes   = nbytes[15:0];
                cmd_n.rec.trk_bit_count = sh_tmp[47:16];
              end
            end
          end
        end
        pp_n = payload_position + 32'd1;
        if (pp_n >= chunk_length) begin
          pp_n    = '0;
          phase_n = PH_CHDR;
        end
      end
      default: begin
      end
    endcase
    if (item.last_byte) begin
      cmd_n.end_vld     = 1'b1;
      cmd_n.end_version = ver_n;
      cmd_n.end_status  = (err_n == ST_OK && phase_n == PH_FILE) ? ST_SHORT : err_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FILE; byte_position <= '0; chunk_kind <= '0; chunk_length <= '0;
      payload_position <= '0; field_shift <= '0; format_version <= '0;
      header_error <= '0; v1_off <= '0; v1_trk <= '0; v1_end <= 33'(V1_ENTRY);
      v1_base <= '0; cmd <= '0;
    end else begin
      cmd <= take ? cmd_n : '0;
      if (take) begin
        if (item.last_byte) begin
          phase <= PH_FILE; byte_position <= '0; chunk_kind <= '0; chunk_length <= '0;
          payload_position <= '0; field_shift <= '0; format_version <= '0;
          header_error <= '0;
        end else begin
          phase <= phase_n; chunk_kind <= kind_n; chunk_length <= len_n;
          payload_position <= pp_n; field_shift <= sh_n; format_version <= ver_n;
          header_error <= err_n;
          if (byte_position != POS_MAX) begin
            byte_position <= byte_position + 1'b1;
          end
        end
        // Entry counters restart with every payload, advance per payload byte.
        if (phase == PH_PAYLOAD && phase_n == PH_PAYLOAD && !item.last_byte) begin
          if (v1_off == V1_ENTRY - 13'd1) begin
            v1_off  <= '0;
            v1_trk  <= v1_trk + 32'd1;
            v1_end  <= v1_end + 33'(V1_ENTRY);
            v1_base <= v1_base + 33'(V1_ENTRY);
          end else begin
            v1_off <= v1_off + 13'd1;
          end
        end else begin
          v1_off  <= '0;
          v1_trk  <= '0;
          v1_end  <= 33'(V1_ENTRY);
          v1_base <= pos_w + 33'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dicp_back.sv
// ----------------------------------------------------------------------------
// dicp_back
// Command queue and result queue: splits each command into result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module dicp_back import dicp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  output logic      room,
  output out_item_t res,
  output logic      empty,
  input  wire logic pop
);

  localparam int DEPTH = 4;

  cmd_t       q [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       part;   // 1: record beat already sent
  logic       push_q, pop_q, beat_done;
  cmd_t       head;

  assign head   = q[rd_ptr];
  assign push_q = cmd.rec_vld | cmd.end_vld;
  assign empty  = (count == '0);
  // Front can have one command in flight; keep slack for it.
  assign room   = (count < 3'(DEPTH - 1));

  always_comb begin
    res = '0;
    if (head.rec_vld && !part) begin
      res = head.rec;
    end else begin
      res.rec_kind     = KIND_END;
      res.info_version = head.end_version;
      res.status       = head.end_status;
    end
  end

  assign beat_done = pop && !empty;
  assign pop_q = beat_done && (!(head.rec_vld && !part) || !head.end_vld);

  always_ff @(posedge clk) begin
    if (push_q) begin
      q[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0; part <= 1'b0;
    end else begin
      if (push_q) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop_q) begin
        rd_ptr <= rd_ptr + 2'd1;
        part   <= 1'b0;
      end else if (beat_done) begin
        part <= 1'b1;
      end
      count <= count + 3'(push_q) - 3'(pop_q);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/disk_image_chunk_parser.sv
// ----------------------------------------------------------------------------
// disk_image_chunk_parser
// Streaming flux-image parser: header check, chunk walk, record output.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// input     in   push / full        in_item_t  (data_byte, last_byte)
// result    out  pop / empty        out_item_t (record fields)
// config    in   APB psel/penable   image_size at address 0
//
// One byte is taken every cycle while full is low; the front parser is a
// single registered stage, so a byte's first result beat passes its cmd register
// and the back queue before it shows. A byte yields at most two result beats (a
// record and the end status); the back queue holds four commands, and full rises
// once three wait, so a slow consumer stalls input.
// rst is synchronous, clears parse state, queues and image_size.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_image_chunk_parser import dicp_pkg::*; #(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [23:0] image_size;
  logic        take, room;
  cmd_t        cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'(REG_IMAGE_SIZE * 4)) ? {8'd0, image_size} : '0;

  // Hold image_size across images; write on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= '0;
    end else if (psel && penable && pwrite && paddr == 2'(REG_IMAGE_SIZE * 4)) begin
      image_size <= pwdata[23:0];
    end
  end

  assign full = !room;
  assign take = push && !full;

  dicp_front #(.MAX_TRACKS(MAX_TRACKS), .ADDR_BITS(ADDR_BITS)) u_front (
    .clk, .rst, .image_size, .take, .item(in_item), .cmd
  );

  dicp_back u_back (
    .clk, .rst, .cmd, .room, .res(out_item), .empty, .pop
  );

endmodule

`default_nettype wire

// File: rtl/core/dicp_checker.sv
// ----------------------------------------------------------------------------
// dicp_checker
// Port-level checks for the disk image chunk parser.
// ----------------------------------------------------------------------------
`default_nettype none

module dicp_checker import dicp_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      full,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t out_item,
  input wire logic      pready
);

  a_ready: assert property (@(posedge clk) pready) else $error("pready low");
  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result after reset");
  a_rst_full: assert property (@(posedge clk) $past(rst) |-> !full)
    else $error("full after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(out_item)) else $error("result changed while stalled");
  a_end_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.rec_kind != KIND_END) |-> out_item.status == ST_OK)
    else $error("status on non-end record");

endmodule

bind disk_image_chunk_parser dicp_checker u_chk (
  .clk, .rst, .full, .empty, .pop, .out_item, .pready
);

`default_nettype wire
